>>> design/efi_pkg.sv
// shared constants, types and the microcode table of the escape-time iterator
// no dependencies
package efi_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int ORBIT_WIDTH = 64;
  localparam int IN_W        = 32;
  localparam int COUNT_W     = 12;
  localparam int BOUND_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // operand width of the multiplies: magnitudes stay below the escape limit
  localparam int OPW   = BOUND_W + FRAC_BITS + 1;
  localparam int HALF  = (OPW + 1) / 2;
  localparam int ACC_W = 4 * HALF;
  localparam int SUM_W = ACC_W + 2;

  localparam logic [COUNT_W-1:0] MAX_ITER_RESET  = COUNT_W'(1000);
  localparam logic [BOUND_W-1:0] ESC_BOUND_RESET = BOUND_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_BOUND = CFG_IDX_W'(1);

  typedef enum logic [1:0] {SH_NONE, SH_HALF, SH_FULL} shift_t;
  typedef enum logic [1:0] {OPS_HOLD, OPS_DIFF_SUM, OPS_MAGS} ops_t;
  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  typedef struct packed {
    logic   mul_en;
    logic   a_hi;
    logic   b_hi;
    logic   acc_en;
    logic   acc_clr;
    shift_t acc_sh;
    ops_t   ld_ops;
    logic   wr_re;
    logic   wr_im;
    logic   check;
    logic   last;
  } ctrl_t;

  typedef struct packed {
    logic at_limit;
    logic escaped;
  } status_t;

  localparam int NUM_STEPS = 12;
  localparam int UPC_W     = $clog2(NUM_STEPS);

  localparam logic [UPC_W-1:0] STEP_CHECK   = UPC_W'(0);
  localparam logic [UPC_W-1:0] STEP_RE_M00  = UPC_W'(1);
  localparam logic [UPC_W-1:0] STEP_RE_M01  = UPC_W'(2);
  localparam logic [UPC_W-1:0] STEP_RE_M10  = UPC_W'(3);
  localparam logic [UPC_W-1:0] STEP_RE_M11  = UPC_W'(4);
  localparam logic [UPC_W-1:0] STEP_RE_ACC  = UPC_W'(5);
  localparam logic [UPC_W-1:0] STEP_IM_M00  = UPC_W'(6);
  localparam logic [UPC_W-1:0] STEP_IM_M01  = UPC_W'(7);
  localparam logic [UPC_W-1:0] STEP_IM_M10  = UPC_W'(8);
  localparam logic [UPC_W-1:0] STEP_IM_M11  = UPC_W'(9);
  localparam logic [UPC_W-1:0] STEP_IM_ACC  = UPC_W'(10);
  localparam logic [UPC_W-1:0] STEP_COMMIT  = UPC_W'(11);

  function automatic ctrl_t ucode(logic [UPC_W-1:0] upc);
    ctrl_t w;
    w = '0;
    w.acc_sh = SH_NONE;
    w.ld_ops = OPS_HOLD;
    case (upc)
      STEP_CHECK: begin
        w.check  = 1'b1;
        w.ld_ops = OPS_DIFF_SUM;
      end
      STEP_RE_M00, STEP_IM_M00: begin
        w.mul_en = 1'b1;
        w.wr_re  = (upc == STEP_IM_M00);
      end
      STEP_RE_M01, STEP_IM_M01: begin
        w.mul_en  = 1'b1;
        w.b_hi    = 1'b1;
        w.acc_en  = 1'b1;
        w.acc_clr = 1'b1;
        w.acc_sh  = SH_NONE;
      end
      STEP_RE_M10, STEP_IM_M10: begin
        w.mul_en = 1'b1;
        w.a_hi   = 1'b1;
        w.acc_en = 1'b1;
        w.acc_sh = SH_HALF;
      end
      STEP_RE_M11, STEP_IM_M11: begin
        w.mul_en = 1'b1;
        w.a_hi   = 1'b1;
        w.b_hi   = 1'b1;
        w.acc_en = 1'b1;
        w.acc_sh = SH_HALF;
      end
      STEP_RE_ACC, STEP_IM_ACC: begin
        w.acc_en = 1'b1;
        w.acc_sh = SH_FULL;
        w.ld_ops = (upc == STEP_RE_ACC) ? OPS_MAGS : OPS_HOLD;
      end
      STEP_COMMIT: begin
        w.wr_im = 1'b1;
        w.last  = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> design/escape_time_fractal_iterator.sv
// Escape-time iterator: one transaction carries z and c in signed Q4.28, the
// result is the number of squarings z = z*z + c done before a component's
// magnitude reaches escape_bound (or the orbit saturates), or 0 when the count
// reaches max_iterations first or at the same test. Both complex products go
// through one shared multiplier as four partial products each, stepped by a
// 12-word microcode program. The next point is taken once the result is in the
// output register, while that result may still wait to be taken.
// Configuration writes go straight into their registers. Depends on efi_pkg,
// efi_seq and efi_datapath.
module escape_time_fractal_iterator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [efi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [efi_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic signed [efi_pkg::IN_W-1:0]    start_re,
  input  logic signed [efi_pkg::IN_W-1:0]    start_im,
  input  logic signed [efi_pkg::IN_W-1:0]    const_re,
  input  logic signed [efi_pkg::IN_W-1:0]    const_im,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [efi_pkg::COUNT_W-1:0]        escape_count
);
  import efi_pkg::*;

  logic [COUNT_W-1:0] max_iterations, count;
  logic [BOUND_W-1:0] escape_bound;
  ctrl_t              ctrl;
  status_t            status;
  logic               idle, done, start, out_free;

  assign item_ready = idle;
  assign start      = item_valid && idle;
  assign out_free   = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
      escape_bound   <= ESC_BOUND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ITER:  max_iterations <= cfg_data[COUNT_W-1:0];
        CFG_ESC_BOUND: escape_bound   <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) escape_count <= status.at_limit ? '0 : count;
  end

  efi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .status   (status),
    .out_free (out_free),
    .ctrl     (ctrl),
    .idle     (idle),
    .done     (done)
  );

  efi_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .start_re       (start_re),
    .start_im       (start_im),
    .const_re       (const_re),
    .const_im       (const_im),
    .ctrl           (ctrl),
    .max_iterations (max_iterations),
    .escape_bound   (escape_bound),
    .status         (status),
    .count          (count)
  );

endmodule

>>> design/efi_seq.sv
// microcode sequencer: step counter, control store lookup and exit branch
// depends on efi_pkg
module efi_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  efi_pkg::status_t status,
  input  logic             out_free,
  output efi_pkg::ctrl_t   ctrl,
  output logic             idle,
  output logic             done
);
  import efi_pkg::*;

  seq_state_t       state, state_next;
  logic [UPC_W-1:0] upc, upc_next;
  ctrl_t            word;
  logic             leave;

  assign word  = ucode(upc);
  assign leave = word.check && (status.at_limit || status.escaped);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      upc   <= STEP_CHECK;
    end else begin
      state <= state_next;
      upc   <= upc_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (start) state_next = SEQ_RUN;
      SEQ_RUN:  if (leave && out_free) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    if (state == SEQ_IDLE) begin
      upc_next = STEP_CHECK;
    end else if (leave || word.last) begin
      upc_next = STEP_CHECK;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  always_comb begin
    idle = (state == SEQ_IDLE);
    done = (state == SEQ_RUN) && leave && out_free;
    if (state == SEQ_RUN && !leave) begin
      ctrl = word;
    end else begin
      ctrl = '0;
    end
  end

endmodule

>>> design/efi_datapath.sv
// orbit registers, shared partial-product multiplier, accumulator,
// saturating add and escape tests; depends on efi_pkg
module efi_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [efi_pkg::IN_W-1:0] start_re,
  input  logic signed [efi_pkg::IN_W-1:0] start_im,
  input  logic signed [efi_pkg::IN_W-1:0] const_re,
  input  logic signed [efi_pkg::IN_W-1:0] const_im,
  input  efi_pkg::ctrl_t                  ctrl,
  input  logic [efi_pkg::COUNT_W-1:0]     max_iterations,
  input  logic [efi_pkg::BOUND_W-1:0]     escape_bound,
  output efi_pkg::status_t                status,
  output logic [efi_pkg::COUNT_W-1:0]     count
);
  import efi_pkg::*;

  localparam int OW = ORBIT_WIDTH;
  localparam logic signed [SUM_W-1:0] POS_MAX = {{(SUM_W-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] NEG_MIN = {{(SUM_W-OW+1){1'b1}}, {(OW-1){1'b0}}};

  logic [OW-1:0]      orbit_re, orbit_im, new_re;
  logic [IN_W-1:0]    cre, cim;
  logic [COUNT_W-1:0] step_counter;
  logic               sat, neg_re, neg_im;
  logic [2*HALF-1:0]  opa, opb, prod, prod_next;
  logic [ACC_W-1:0]   acc, acc_next, acc_term;

  logic [OW-1:0]      ax, ay, lim;
  logic [OPW-1:0]     axn, ayn, dif, sum_ops;
  logic               dneg;
  logic [HALF-1:0]    a_part, b_part;
  logic [ACC_W-1:0]   mag;
  logic signed [SUM_W-1:0] mag_s, term, total;
  logic [OW-1:0]      sat_val;
  logic               sat_hit;

  assign ax  = orbit_re[OW-1] ? (~orbit_re + OW'(1)) : orbit_re;
  assign ay  = orbit_im[OW-1] ? (~orbit_im + OW'(1)) : orbit_im;
  assign lim = OW'({escape_bound, {FRAC_BITS{1'b0}}});

  assign status.at_limit = (step_counter == max_iterations);
  assign status.escaped  = sat || (ax >= lim) || (ay >= lim);
  assign count           = step_counter;

  assign axn     = ax[OPW-1:0];
  assign ayn     = ay[OPW-1:0];
  assign dneg    = axn < ayn;
  assign dif     = dneg ? (ayn - axn) : (axn - ayn);
  assign sum_ops = axn + ayn;

  assign a_part    = ctrl.a_hi ? opa[2*HALF-1:HALF] : opa[HALF-1:0];
  assign b_part    = ctrl.b_hi ? opb[2*HALF-1:HALF] : opb[HALF-1:0];
  assign prod_next = {{HALF{1'b0}}, a_part} * {{HALF{1'b0}}, b_part};

  always_comb begin
    case (ctrl.acc_sh)
      SH_NONE: acc_term = ACC_W'(prod);
      SH_HALF: acc_term = ACC_W'(prod) << HALF;
      SH_FULL: acc_term = ACC_W'(prod) << (2 * HALF);
      default: acc_term = '0;
    endcase
    acc_next = (ctrl.acc_clr ? '0 : acc) + acc_term;
  end

  // scale the exact product, apply its sign, add c and clamp to the orbit range
  always_comb begin
    mag   = ctrl.wr_im ? (acc >> (FRAC_BITS - 1)) : (acc >> FRAC_BITS);
    mag_s = $signed({2'b00, mag});
    if (ctrl.wr_im ? neg_im : neg_re) begin
      term = -mag_s;
    end else begin
      term = mag_s;
    end
    if (ctrl.wr_im) begin
      total = term + $signed({{(SUM_W-IN_W){cim[IN_W-1]}}, cim});
    end else begin
      total = term + $signed({{(SUM_W-IN_W){cre[IN_W-1]}}, cre});
    end
    if (total > POS_MAX) begin
      sat_val = POS_MAX[OW-1:0];
      sat_hit = 1'b1;
    end else if (total < NEG_MIN) begin
      sat_val = NEG_MIN[OW-1:0];
      sat_hit = 1'b1;
    end else begin
      sat_val = total[OW-1:0];
      sat_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter <= '0;
      sat          <= 1'b0;
    end else if (start) begin
      step_counter <= '0;
      sat          <= 1'b0;
    end else begin
      if (ctrl.wr_re || ctrl.wr_im) sat <= sat | sat_hit;
      if (ctrl.wr_im) step_counter <= step_counter + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      orbit_re <= {{(OW-IN_W){start_re[IN_W-1]}}, start_re};
      orbit_im <= {{(OW-IN_W){start_im[IN_W-1]}}, start_im};
      cre      <= const_re;
      cim      <= const_im;
    end else begin
      case (ctrl.ld_ops)
        OPS_DIFF_SUM: begin
          opa    <= (2*HALF)'(dif);
          opb    <= (2*HALF)'(sum_ops);
          neg_re <= dneg;
          neg_im <= orbit_re[OW-1] ^ orbit_im[OW-1];
        end
        OPS_MAGS: begin
          opa <= (2*HALF)'(axn);
          opb <= (2*HALF)'(ayn);
        end
        default: ;
      endcase
      if (ctrl.mul_en) prod <= prod_next;
      if (ctrl.acc_en) acc <= acc_next;
      if (ctrl.wr_re) new_re <= sat_val;
      if (ctrl.wr_im) begin
        orbit_re <= new_re;
        orbit_im <= sat_val;
      end
    end
  end

endmodule

>>> design/efi_checker.sv
// port-level checks of the escape-time iterator, bound to its top level
// depends on efi_pkg and escape_time_fractal_iterator
module efi_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [efi_pkg::COUNT_W-1:0]    escape_count
);
  import efi_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(escape_count))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("engine took a second point while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result appeared before any escape test");

  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> item_ready)
    else $error("engine still busy when its result was posted");

  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    item_ready && !item_valid |=> item_ready)
    else $error("engine left idle without a transaction");

endmodule

bind escape_time_fractal_iterator efi_checker u_efi_checker (.*);
